>>> sv/segmented_packet_reassembler_defines.svh
// Assertion macros shared by the reassembler modules.
`ifndef SEGMENTED_PACKET_REASSEMBLER_DEFINES_SVH
`define SEGMENTED_PACKET_REASSEMBLER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SPR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> sv/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Types and constants shared by the segmented packet reassembler.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int PacketBytes = 4096;
  localparam int MaxChunk = 512;
  localparam int ControlFrameBytes = 16;
  localparam int DataHeaderBytes = 14;
  localparam int AddrW = $clog2(PacketBytes);
  localparam int CountW = AddrW + 1;

  // Error codes, in check order.
  localparam logic [3:0] ErrNone = 4'd0;
  localparam logic [3:0] ErrAuth = 4'd1;
  localparam logic [3:0] ErrLength = 4'd2;
  localparam logic [3:0] ErrMagic = 4'd3;
  localparam logic [3:0] ErrVersion = 4'd4;
  localparam logic [3:0] ErrFlags = 4'd5;
  localparam logic [3:0] ErrPacketSize = 4'd6;
  localparam logic [3:0] ErrOperation = 4'd7;
  localparam logic [3:0] ErrFrameSize = 4'd8;
  localparam logic [3:0] ErrNoTransfer = 4'd9;
  localparam logic [3:0] ErrId = 4'd10;
  localparam logic [3:0] ErrOffset = 4'd11;
  localparam logic [3:0] ErrExcess = 4'd12;

  // Configuration register indexes.
  localparam logic [1:0] RegMinVersion = 2'd0;
  localparam logic [1:0] RegMaxVersion = 2'd1;
  localparam logic [1:0] RegDefaultVersion = 2'd2;
  localparam logic [1:0] RegMinPacketSize = 2'd3;

  // Control operations.
  localparam logic [7:0] OpStart = 8'd1;
  localparam logic [7:0] OpAbort = 8'd2;

  localparam logic [31:0] CtlMagic = 32'h43455342;
  localparam logic [31:0] DatMagic = 32'h43455344;

  typedef struct packed {
    logic        kind;
    logic        is_control;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        secure;
    logic [11:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  error_code;
    logic        active;
    logic        complete;
    logic [12:0] received_count;
    logic [12:0] announced_size;
    logic [31:0] current_id;
    logic [7:0]  current_version;
    logic [7:0]  read_data;
  } out_item_t;

  // Status of the transfer, passed from the frame logic to the output stage.
  typedef struct packed {
    logic [3:0]  error_code;
    logic        active;
    logic        complete;
    logic [12:0] received_count;
    logic [12:0] announced_size;
    logic [31:0] current_id;
    logic [7:0]  current_version;
  } status_t;

endpackage

>>> sv/spr_ram.sv
// ----------------------------------------------------------------------------
// spr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module spr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/spr_frame.sv
// ----------------------------------------------------------------------------
// spr_frame
// Frame collector and checker: keeps the header bytes and transfer state,
// computes store writes, and evaluates a frame on its last beat.
// ----------------------------------------------------------------------------
`include "segmented_packet_reassembler_defines.svh"

module spr_frame (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  spr_pkg::in_item_t        item,
  input  logic [7:0]               min_version,
  input  logic [7:0]               max_version,
  input  logic [7:0]               default_version,
  input  logic [12:0]              min_packet_size,
  output logic                     st_we,
  output logic [spr_pkg::AddrW-1:0] st_waddr,
  output logic [7:0]               st_wdata,
  output logic                     read_hit,
  output spr_pkg::status_t         status
);

  logic [7:0]  hdr [16];
  logic [15:0] flen;
  logic [31:0] tid;
  logic [12:0] expected;
  logic [12:0] received;
  logic [9:0]  chunk;
  logic [7:0]  version;
  logic        active;

  logic [15:0] len;
  logic [7:0]  h [16];
  logic [3:0]  err;
  logic        do_clear;
  logic        do_start;
  logic        do_append;
  logic        do_latch;
  logic [15:0] psz;
  logic [15:0] fsz;
  logic [15:0] dsz;
  logic [31:0] hid;
  logic [16:0] waddr_full;
  logic        frame_beat;
  logic        eval;

  assign frame_beat = take && !item.kind;
  assign eval = frame_beat && item.last_byte;
  assign len = (flen == 16'hFFFF) ? 16'hFFFF : flen + 16'd1;

  // Header view with the current byte merged in.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      h[i] = (flen == 16'(i)) ? item.frame_byte : hdr[i];
    end
  end

  assign psz = {h[12], h[13]};
  assign fsz = {h[14], h[15]};
  assign dsz = {h[12], h[13]};

  // Payload bytes go straight to the store behind the accepted bytes.
  assign waddr_full = 17'(received) + 17'(flen) - 17'(spr_pkg::DataHeaderBytes);
  assign st_we = frame_beat && !item.is_control &&
                 (flen >= 16'(spr_pkg::DataHeaderBytes)) &&
                 (waddr_full < 17'(spr_pkg::PacketBytes));
  assign st_waddr = waddr_full[spr_pkg::AddrW-1:0];
  assign st_wdata = item.frame_byte;

  assign read_hit = (13'(item.read_index) < received);

  // Frame checks in order; first failure wins.
  always_comb begin
    err = spr_pkg::ErrNone;
    do_clear = 1'b0;
    do_start = 1'b0;
    do_append = 1'b0;
    do_latch = 1'b0;
    hid = '0;
    if (item.is_control) begin
      hid = {h[8], h[9], h[10], h[11]};
      if (!item.secure) begin
        err = spr_pkg::ErrAuth;
        do_clear = 1'b1;
      end else if (len != 16'(spr_pkg::ControlFrameBytes)) begin
        err = spr_pkg::ErrLength;
      end else if ({h[0], h[1], h[2], h[3]} != spr_pkg::CtlMagic) begin
        err = spr_pkg::ErrMagic;
      end else if (h[4] < min_version || h[4] > max_version) begin
        err = spr_pkg::ErrVersion;
      end else begin
        do_latch = 1'b1;
        if (h[6] != 8'd0 || h[7] != 8'd0) begin
          err = spr_pkg::ErrFlags;
        end else if (h[5] == spr_pkg::OpAbort) begin
          if (psz != 16'd0 || fsz != 16'd0) begin
            err = spr_pkg::ErrPacketSize;
          end else begin
            do_clear = 1'b1;
          end
        end else if (h[5] != spr_pkg::OpStart) begin
          err = spr_pkg::ErrOperation;
        end else if (psz < 16'(min_packet_size) ||
                     psz > 16'(spr_pkg::PacketBytes)) begin
          err = spr_pkg::ErrPacketSize;
        end else if (fsz == 16'd0 || fsz > 16'(spr_pkg::MaxChunk)) begin
          err = spr_pkg::ErrFrameSize;
        end else begin
          do_start = 1'b1;
        end
      end
    end else begin
      hid = {h[6], h[7], h[8], h[9]};
      if (!item.secure) begin
        err = spr_pkg::ErrAuth;
        do_clear = 1'b1;
      end else if (len < 16'(spr_pkg::DataHeaderBytes + 1)) begin
        err = spr_pkg::ErrLength;
      end else if ({h[0], h[1], h[2], h[3]} != spr_pkg::DatMagic) begin
        err = spr_pkg::ErrMagic;
      end else if (h[4] < min_version || h[4] > max_version || h[4] != version) begin
        err = spr_pkg::ErrVersion;
      end else if (h[5] != 8'd0) begin
        err = spr_pkg::ErrFlags;
      end else if (!active || received == expected) begin
        err = spr_pkg::ErrNoTransfer;
      end else if (hid != tid) begin
        err = spr_pkg::ErrId;
      end else if ({h[10], h[11]} != 16'(received)) begin
        err = spr_pkg::ErrOffset;
      end else if (dsz == 16'd0 || dsz > 16'(chunk) ||
                   len != dsz + 16'(spr_pkg::DataHeaderBytes)) begin
        err = spr_pkg::ErrFrameSize;
      end else if (dsz > 16'(expected - received)) begin
        err = spr_pkg::ErrExcess;
      end else begin
        do_append = 1'b1;
      end
    end
  end

  // Header bytes and frame length.
  always_ff @(posedge clk) begin
    if (rst) begin
      flen <= '0;
      for (int i = 0; i < 16; i++) begin
        hdr[i] <= '0;
      end
    end else if (frame_beat) begin
      for (int i = 0; i < 16; i++) begin
        hdr[i] <= h[i];
      end
      flen <= item.last_byte ? 16'd0 : len;
    end
  end

  // Transfer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tid <= '0;
      expected <= '0;
      received <= '0;
      chunk <= '0;
      version <= default_version;
      active <= 1'b0;
    end else if (eval) begin
      if (do_clear) begin
        tid <= '0;
        expected <= '0;
        received <= '0;
        chunk <= '0;
        version <= default_version;
        active <= 1'b0;
      end else begin
        if (do_latch) begin
          version <= h[4];
        end
        if (do_start) begin
          tid <= hid;
          expected <= psz[12:0];
          received <= '0;
          chunk <= fsz[9:0];
          active <= 1'b1;
        end
        if (do_append) begin
          received <= received + dsz[12:0];
        end
      end
    end
  end

  // Status after this beat, as the output stage will show it.
  always_comb begin
    status.error_code = (eval) ? err : spr_pkg::ErrNone;
    status.active = active;
    status.complete = active && (received == expected);
    status.received_count = received;
    status.announced_size = expected;
    status.current_id = tid;
    status.current_version = version;
  end

  `SPR_ASSERT_IMP(a_recv_le_exp, clk, rst, active, received <= expected,
                  "received count exceeds announced size")
  `SPR_ASSERT_NEXT(a_clear, clk, rst, eval && do_clear, !active && received == 13'd0,
                   "clear left transfer active")
  `SPR_ASSERT_NEXT(a_flen_rst, clk, rst, eval, flen == 16'd0,
                   "frame length not reset after last beat")

endmodule

>>> sv/segmented_packet_reassembler.sv
// ----------------------------------------------------------------------------
// segmented_packet_reassembler
// Reassembles a packet from checked data frames into a byte store.
// ----------------------------------------------------------------------------
// Channel  | Signals                     | Beat
// in       | in_valid/in_ready/in_data   | one frame byte or one read
// out      | out_valid/out_ready/out_data| one result per last byte or read
// cfg      | cfg_valid/cfg_ready/idx/data| one register write
//
// One input beat per cycle while in_ready is high. A result passes through
// the registered store read and result stage, then the output register. The
// output stage holds one result and a skid register one more; input stalls
// while the skid register is full, or while a result is about to enter it
// behind a stalled output. Reset is synchronous; the store is not cleared.
// ----------------------------------------------------------------------------
`include "segmented_packet_reassembler_defines.svh"

module segmented_packet_reassembler (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spr_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output spr_pkg::out_item_t    out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [12:0]           cfg_data
);

  logic [7:0]  min_version;
  logic [7:0]  max_version;
  logic [7:0]  default_version;
  logic [12:0] min_packet_size;

  logic                      take;
  logic                      st_we;
  logic [spr_pkg::AddrW-1:0] st_waddr;
  logic [7:0]                st_wdata;
  logic [7:0]                st_rdata;
  logic                      read_hit;
  spr_pkg::status_t          status;

  // Stage 1 holds the result while the store read completes.
  logic                      s1_valid;
  logic                      s1_read;
  logic                      s1_hit;
  logic [3:0]                s1_err;
  spr_pkg::out_item_t        s1_item;
  spr_pkg::status_t          st_now;

  // Output register and skid register.
  logic                      skid_valid;
  spr_pkg::out_item_t        skid_data;

  assign cfg_ready = 1'b1;
  // A beat may enter only if its result will find room behind the output.
  assign in_ready = !skid_valid && !(s1_valid && out_valid && !out_ready);
  assign take = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_version <= 8'd1;
      max_version <= 8'd1;
      default_version <= 8'd1;
      min_packet_size <= 13'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        spr_pkg::RegMinVersion: min_version <= cfg_data[7:0];
        spr_pkg::RegMaxVersion: max_version <= cfg_data[7:0];
        spr_pkg::RegDefaultVersion: default_version <= cfg_data[7:0];
        spr_pkg::RegMinPacketSize: min_packet_size <= cfg_data;
        default: ;
      endcase
    end
  end

  spr_frame u_frame (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .item            (in_data),
    .min_version     (min_version),
    .max_version     (max_version),
    .default_version (default_version),
    .min_packet_size (min_packet_size),
    .st_we           (st_we),
    .st_waddr        (st_waddr),
    .st_wdata        (st_wdata),
    .read_hit        (read_hit),
    .status          (status)
  );

  spr_ram #(
    .Width (8),
    .Depth (spr_pkg::PacketBytes)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (take && in_data.kind),
    .raddr (in_data.read_index[spr_pkg::AddrW-1:0]),
    .rdata (st_rdata)
  );

  // Result stage: the transfer state after the beat is the registered state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take && (in_data.kind || in_data.last_byte);
    end
    s1_read <= in_data.kind;
    s1_hit <= read_hit;
    s1_err <= status.error_code;
  end

  assign st_now = status;

  always_comb begin
    s1_item.error_code = s1_read ? spr_pkg::ErrNone : s1_err;
    s1_item.active = st_now.active;
    s1_item.complete = st_now.complete;
    s1_item.received_count = st_now.received_count;
    s1_item.announced_size = st_now.announced_size;
    s1_item.current_id = st_now.current_id;
    s1_item.current_version = st_now.current_version;
    s1_item.read_data = (s1_read && s1_hit) ? st_rdata : 8'd0;
  end

  // Output register with skid: a new result parks in skid when output stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          skid_valid <= s1_valid;
        end else begin
          out_valid <= s1_valid;
        end
      end else if (s1_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : s1_item;
      if (skid_valid) begin
        skid_data <= s1_item;
      end
    end else if (s1_valid) begin
      skid_data <= s1_item;
    end
  end

  `SPR_ASSERT_NEXT(a_skid_stall, clk, rst, skid_valid, !s1_valid,
                   "result stage filled while skid register full")
  `SPR_ASSERT_IMP(a_skid_has_out, clk, rst, skid_valid, out_valid,
                  "skid register full with empty output")
  `SPR_ASSERT_IMP(a_read_err, clk, rst, s1_valid && s1_read,
                  s1_item.error_code == spr_pkg::ErrNone,
                  "read result carries an error code")

endmodule
